### sv/bba_pkg.sv
// shared types, constants and codes for the buddy allocator
package bba_pkg;

    localparam int LEVELS_DEF      = 8;
    localparam int CHUNK_BYTES_DEF = 128;

    localparam int ADDR_W = 48;
    localparam int REQ_W  = 32;
    localparam int FLAG_W = 3;

    localparam logic [FLAG_W-1:0] F_VALID = 3'b001;
    localparam logic [FLAG_W-1:0] F_SPLIT = 3'b010;
    localparam logic [FLAG_W-1:0] F_ALLOC = 3'b100;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_SIZE,
        OP_SCAN_RD,
        OP_SCAN_CK,
        OP_SPLIT_WR,
        OP_LEFT_RD,
        OP_LEFT_WR,
        OP_RIGHT_RD,
        OP_RIGHT_WR,
        OP_ALLOC_WR,
        OP_FREE_OFF,
        OP_FREE_START,
        OP_CLIMB_RD,
        OP_CLIMB_CK,
        OP_MERGE_ME,
        OP_BUD_RD,
        OP_BUD_CK,
        OP_MERGE_UP,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_status;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic size_fit;
        logic size_last;
        logic node_free;
        logic idx_last;
        logic lvl_zero;
        logic lvl_at_target;
        logic child_at_target;
        logic range_bad;
        logic rem_nz;
        logic node_valid;
        logic idx_odd;
        logic buddy_busy;
    } dp_stat_t;

endpackage

### sv/bba_ram.sv
// generic single write port ram with registered read
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/bba_datapath.sv
// node store, level and index registers, offset split and result register
module bba_datapath
    import bba_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic [79:0]       s_tdata,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    localparam int NODES      = (2 ** LEVELS) - 1;
    localparam int NAW        = LEVELS;
    localparam int IW         = LEVELS - 1;
    localparam int LW         = $clog2(LEVELS);
    localparam int HEAP_BYTES = CHUNK_BYTES * (2 ** (LEVELS - 1));
    localparam int OFFW       = $clog2(HEAP_BYTES);
    localparam int CHUNK_LG   = $clog2(CHUNK_BYTES);

    logic [ADDR_W-1:0]   heap_base_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [NAW-1:0]      clr_cnt_reg;
    logic [LW-1:0]       k_reg;
    logic [LW-1:0]       lvl_reg;
    logic [LW-1:0]       target_reg;
    logic [IW-1:0]       idx_reg;
    logic [FLAG_W-1:0]   cur_reg;
    logic [CHUNK_LG-1:0] rem_reg;
    logic [IW-1:0]       q_reg;
    logic [OFFW-1:0]     blk_reg;
    logic                grant_reg;
    status_t             res_status_reg;
    logic [ADDR_W-1:0]   granted_reg;
    status_t             status_reg;

    logic              ram_we;
    logic [NAW-1:0]    ram_waddr;
    logic [FLAG_W-1:0] ram_wdata;
    logic              ram_re;
    logic [NAW-1:0]    ram_raddr;
    logic [FLAG_W-1:0] ram_rdata;

    logic [NAW-1:0]    a_cur;
    logic [NAW-1:0]    a_left;
    logic [NAW-1:0]    a_right;
    logic [NAW-1:0]    a_bud;
    logic [NAW-1:0]    idx_ext;
    logic [NAW-1:0]    lvl_last;
    logic [LW-1:0]     lvl_up;
    logic [REQ_W-1:0]  chunk_sz;
    logic [ADDR_W-1:0] diff;
    logic [IW-1:0]     chunk_idx;
    logic [OFFW-1:0]   blk_off;

    function automatic logic [NAW-1:0] node_addr(input logic [LW-1:0] l,
                                                 input logic [NAW-1:0] i);
        node_addr = (NAW'(1) << l) - NAW'(1) + i;
    endfunction

    assign idx_ext   = NAW'(idx_reg);
    assign lvl_up    = lvl_reg + LW'(1);
    assign a_cur     = node_addr(lvl_reg, idx_ext);
    assign a_left    = node_addr(lvl_up, idx_ext << 1);
    assign a_right   = a_left + NAW'(1);
    assign a_bud     = node_addr(lvl_reg, idx_ext ^ NAW'(1));
    assign lvl_last  = (NAW'(1) << lvl_reg) - NAW'(1);
    assign chunk_sz  = REQ_W'(CHUNK_BYTES) << k_reg;
    assign diff      = addr_reg - heap_base_reg;
    assign chunk_idx = idx_reg << (LW'(LEVELS - 1) - lvl_reg);
    assign blk_off   = OFFW'(OFFW'(chunk_idx) * OFFW'(CHUNK_BYTES));

    always_comb begin
        stat.clr_last        = clr_cnt_reg == NAW'(NODES - 1);
        stat.size_fit        = chunk_sz >= req_reg;
        stat.size_last       = k_reg == LW'(LEVELS - 1);
        stat.node_free       = ((ram_rdata & F_VALID) != '0)
                               && ((ram_rdata & (F_SPLIT | F_ALLOC)) == '0);
        stat.idx_last        = idx_ext == lvl_last;
        stat.lvl_zero        = lvl_reg == '0;
        stat.lvl_at_target   = lvl_reg == target_reg;
        stat.child_at_target = lvl_up == target_reg;
        stat.range_bad       = diff >= ADDR_W'(HEAP_BYTES);
        stat.rem_nz          = rem_reg != '0;
        stat.node_valid      = (ram_rdata & F_VALID) != '0;
        stat.idx_odd         = idx_reg[0];
        stat.buddy_busy      = (ram_rdata & (F_SPLIT | F_ALLOC)) != '0;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = a_cur;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = a_cur;
        unique case (cmd.op)
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = (clr_cnt_reg == '0) ? F_VALID : '0;
            end
            OP_SCAN_RD, OP_CLIMB_RD: begin
                ram_re = 1'b1;
            end
            OP_SPLIT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = cur_reg | F_SPLIT | F_VALID;
            end
            OP_LEFT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = a_left;
            end
            OP_LEFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = a_left;
                ram_wdata = ram_rdata | F_VALID;
            end
            OP_RIGHT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = a_right;
            end
            OP_RIGHT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = a_right;
                ram_wdata = ram_rdata | F_VALID;
            end
            OP_ALLOC_WR: begin
                ram_we    = 1'b1;
                ram_wdata = cur_reg | F_ALLOC;
            end
            OP_MERGE_ME: begin
                ram_we    = 1'b1;
                ram_wdata = F_VALID;
            end
            OP_BUD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = a_bud;
            end
            OP_BUD_CK: begin
                ram_we    = !stat.buddy_busy;
                ram_waddr = a_bud;
            end
            OP_MERGE_UP: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    bba_ram #(
        .WIDTH(FLAG_W),
        .DEPTH(NODES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            clr_cnt_reg   <= '0;
        end else begin
            if (cfg_wen) begin
                heap_base_reg <= cfg_wdata;
            end
            if (cmd.op == OP_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + NAW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_status) begin
            res_status_reg <= cmd.code;
        end
        unique case (cmd.op)
            OP_ACCEPT: begin
                req_reg        <= s_tdata[31:0];
                addr_reg       <= s_tdata[79:32];
                k_reg          <= '0;
                grant_reg      <= 1'b0;
                res_status_reg <= ST_OK;
            end
            OP_SIZE: begin
                if (stat.size_fit) begin
                    target_reg <= LW'(LEVELS - 1) - k_reg;
                    lvl_reg    <= LW'(LEVELS - 1) - k_reg;
                    idx_reg    <= '0;
                end else begin
                    k_reg <= k_reg + LW'(1);
                end
            end
            OP_SCAN_CK: begin
                if (stat.node_free) begin
                    cur_reg <= ram_rdata;
                end else if (stat.idx_last) begin
                    lvl_reg <= lvl_reg - LW'(1);
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            OP_LEFT_WR: begin
                cur_reg <= ram_rdata | F_VALID;
            end
            OP_RIGHT_WR: begin
                lvl_reg <= lvl_up;
                idx_reg <= idx_reg << 1;
            end
            OP_ALLOC_WR: begin
                blk_reg   <= blk_off;
                grant_reg <= 1'b1;
            end
            OP_FREE_OFF: begin
                rem_reg <= diff[CHUNK_LG-1:0];
                q_reg   <= diff[OFFW-1:CHUNK_LG];
            end
            OP_FREE_START: begin
                lvl_reg <= LW'(LEVELS - 1);
                idx_reg <= q_reg;
            end
            OP_CLIMB_CK: begin
                if (!stat.node_valid) begin
                    lvl_reg <= lvl_reg - LW'(1);
                    idx_reg <= idx_reg >> 1;
                end
            end
            OP_MERGE_UP: begin
                lvl_reg <= lvl_reg - LW'(1);
                idx_reg <= idx_reg >> 1;
            end
            OP_LOAD_OUT: begin
                granted_reg <= grant_reg ? (heap_base_reg + ADDR_W'(blk_reg)) : '0;
                status_reg  <= res_status_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = granted_reg;
    assign m_tuser = status_reg;

endmodule

### sv/bba_ctrl.sv
// sequencer for allocate and free transactions, clearing pass and output handshake
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_tuser,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SIZE, S_SRD, S_SCK, S_SPW, S_LRD, S_LWR, S_RRD, S_RWR,
        S_AW, S_FOFF, S_FREM, S_CRD, S_CCK, S_MW, S_BRD, S_BCK, S_MZ,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb begin
        state_next     = state_reg;
        cmd.op         = OP_IDLE;
        cmd.set_status = 1'b0;
        cmd.code       = ST_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = (s_tuser == MODE_FREE) ? S_FOFF : S_SIZE;
                end
            end
            S_SIZE: begin
                cmd.op = OP_SIZE;
                priority if (stat.size_fit) begin
                    state_next = S_SRD;
                end else if (stat.size_last) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_NOSPACE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_SIZE;
                end
            end
            S_SRD: begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_SCK;
            end
            S_SCK: begin
                cmd.op = OP_SCAN_CK;
                priority if (stat.node_free) begin
                    state_next = stat.lvl_at_target ? S_AW : S_SPW;
                end else if (stat.idx_last && stat.lvl_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_NOSPACE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_SRD;
                end
            end
            S_SPW: begin
                cmd.op     = OP_SPLIT_WR;
                state_next = S_LRD;
            end
            S_LRD: begin
                cmd.op     = OP_LEFT_RD;
                state_next = S_LWR;
            end
            S_LWR: begin
                cmd.op     = OP_LEFT_WR;
                state_next = S_RRD;
            end
            S_RRD: begin
                cmd.op     = OP_RIGHT_RD;
                state_next = S_RWR;
            end
            S_RWR: begin
                cmd.op     = OP_RIGHT_WR;
                state_next = stat.child_at_target ? S_AW : S_SPW;
            end
            S_AW: begin
                cmd.op     = OP_ALLOC_WR;
                state_next = S_DONE;
            end
            S_FOFF: begin
                cmd.op = OP_FREE_OFF;
                if (stat.range_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_BADFREE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_FREM;
                end
            end
            S_FREM: begin
                cmd.op = OP_FREE_START;
                if (stat.rem_nz) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_BADFREE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_CRD;
                end
            end
            S_CRD: begin
                cmd.op     = OP_CLIMB_RD;
                state_next = S_CCK;
            end
            S_CCK: begin
                cmd.op = OP_CLIMB_CK;
                priority if (stat.node_valid) begin
                    state_next = S_MW;
                end else if (stat.lvl_zero || stat.idx_odd) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_BADFREE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_CRD;
                end
            end
            S_MW: begin
                cmd.op     = OP_MERGE_ME;
                state_next = stat.lvl_zero ? S_DONE : S_BRD;
            end
            S_BRD: begin
                cmd.op     = OP_BUD_RD;
                state_next = S_BCK;
            end
            S_BCK: begin
                cmd.op     = OP_BUD_CK;
                state_next = stat.buddy_busy ? S_DONE : S_MZ;
            end
            S_MZ: begin
                cmd.op     = OP_MERGE_UP;
                state_next = S_MW;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op     = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.op == OP_LOAD_OUT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;

endmodule

### sv/buddy_allocator_tree.sv
// top level of the binary buddy allocator
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   tdata: request_bytes, block_address  tuser: mode
//  m_       out  m_tvalid/m_tready   tdata: granted_address               tuser: status
//  cfg_     in   cfg_wen             cfg_wdata: heap_base
//
// after reset a clearing pass writes all 2^LEVELS-1 nodes, one per cycle, s_tready low
// allocate: accept, size steps, read and check per node scanned, split and child writes
// per split level, allocation write; free: accept, offset, alignment, read and check per
// level climbed, merge, buddy read and check, merge up; one in flight at a time
// a waiting result sits in the output register, the next transaction is taken meanwhile
module buddy_allocator_tree
    import bba_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // request_bytes [31:0], block_address [79:32]
    input  logic              s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // granted_address [47:0]
    output logic [1:0]        m_tuser    // status [1:0]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bba_datapath #(
        .LEVELS      (LEVELS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### sv/bba_checker.sv
// port-level checks for the buddy allocator and their binding
module bba_checker
    import bba_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_clear_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOSPACE || m_tuser == ST_BADFREE))
        else $error("undefined status code");

    a_error_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed transaction carries an address");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind buddy_allocator_tree bba_checker u_bba_checker (.*);

### tb/sv/buddy_tree_checker.sv
// checker for the buddy allocator: mirrors the node tree and compares every result transaction
module buddy_tree_checker
    import bba_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [79:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,
    input  logic [1:0]        m_tuser,
    output int unsigned       mismatches,
    output int unsigned       awaited
);

    localparam int NODES = (1 << LEVELS) - 1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           code;
    } grant_t;

    logic [FLAG_W-1:0] tree [NODES];
    logic [ADDR_W-1:0] heap_origin;
    grant_t            awaited_grants [$];

    initial mismatches = 0;
    initial awaited = 0;

    function automatic int slot(int lvl, int idx);
        return (1 << lvl) - 1 + idx;
    endfunction

    function automatic longint unsigned span(int lvl);
        return longint'(CHUNK_BYTES) << (LEVELS - 1 - lvl);
    endfunction

    function automatic grant_t tree_alloc(logic [REQ_W-1:0] req);
        grant_t            g;
        longint unsigned   need;
        logic [ADDR_W-1:0] offs;
        int                k, target, lvl, idx, n;
        bit                found;
        g.addr = '0;
        g.code = ST_NOSPACE;
        need = 64'(req);
        if (need < CHUNK_BYTES) need = 64'(CHUNK_BYTES);
        k = 0;
        while (k < LEVELS && span(LEVELS - 1 - k) < need) k++;
        if (k >= LEVELS) return g;
        target = LEVELS - 1 - k;
        lvl = target;
        idx = 0;
        found = 0;
        forever begin
            for (idx = 0; idx < (1 << lvl); idx++) begin
                n = slot(lvl, idx);
                if ((tree[n] & F_VALID) != 0 && (tree[n] & (F_SPLIT | F_ALLOC)) == 0) begin
                    found = 1;
                    break;
                end
            end
            if (found || lvl == 0) break;
            lvl--;
        end
        if (!found) return g;
        while (lvl < target) begin
            tree[slot(lvl, idx)] |= F_SPLIT | F_VALID;
            tree[slot(lvl + 1, 2 * idx)] |= F_VALID;
            tree[slot(lvl + 1, 2 * idx + 1)] |= F_VALID;
            lvl++;
            idx = idx << 1;
        end
        tree[slot(lvl, idx)] |= F_ALLOC;
        offs = ADDR_W'(64'(idx) * span(lvl));
        g.addr = heap_origin + offs;
        g.code = ST_OK;
        return g;
    endfunction

    function automatic grant_t tree_free(logic [ADDR_W-1:0] addr_in);
        grant_t            g;
        logic [ADDR_W-1:0] off;
        int                lvl, idx, me, bud;
        g.addr = '0;
        g.code = ST_BADFREE;
        off = addr_in - heap_origin;
        if (off >= span(0)) return g;
        lvl = LEVELS - 1;
        idx = int'(off / CHUNK_BYTES);
        // climb to the first valid node on the path
        forever begin
            if (off % span(lvl) != 0) return g;
            if ((tree[slot(lvl, idx)] & F_VALID) != 0) break;
            if (lvl == 0) return g;
            idx = idx >> 1;
            lvl--;
        end
        // release and merge with free buddies
        forever begin
            me = slot(lvl, idx);
            tree[me] = F_VALID;
            if (lvl == 0) break;
            bud = slot(lvl, idx ^ 1);
            if ((tree[bud] & (F_SPLIT | F_ALLOC)) != 0) break;
            tree[bud] = '0;
            tree[me] = '0;
            idx = idx >> 1;
            lvl--;
        end
        g.code = ST_OK;
        return g;
    endfunction

    task automatic flag_error(string what, grant_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d (%s): expected addr %h status %0d, got addr %h status %0d",
                     mismatches, what, want.addr, want.code, m_tdata, m_tuser);
    endtask

    always @(posedge aclk) begin : watch
        grant_t want;
        if (!aresetn) begin
            foreach (tree[i]) tree[i] = '0;
            tree[0] = F_VALID;
            heap_origin = '0;
            awaited_grants.delete();
        end else begin
            if (cfg_wen) heap_origin = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (awaited_grants.size() == 0) begin
                    want = '0;
                    flag_error("result with nothing pending", want);
                end else begin
                    want = awaited_grants.pop_front();
                    if (want.addr !== m_tdata || want.code !== m_tuser)
                        flag_error("field mismatch", want);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_FREE)
                    awaited_grants.push_back(tree_free(s_tdata[79:32]));
                else
                    awaited_grants.push_back(tree_alloc(s_tdata[31:0]));
            end
        end
        awaited = awaited_grants.size();
    end

endmodule

### tb/sv/buddy_allocator_tree_tb.sv
// testbench top for the buddy allocator: clock, reset, stimulus, watchdog and verdict
module buddy_allocator_tree_tb
    import bba_pkg::*;
();

    localparam int LEVELS        = LEVELS_DEF;
    localparam int CHUNK_BYTES   = CHUNK_BYTES_DEF;
    localparam int HEAP_BYTES    = CHUNK_BYTES << (LEVELS - 1);
    localparam int HEAP_CHUNKS   = 1 << (LEVELS - 1);
    localparam int SETTLE_CYCLES = 700;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_ITEMS   = 500;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [79:0]       s_tdata   = '0;  // request_bytes [31:0], block_address [79:32]
    logic              s_tuser   = 1'b0; // mode
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;          // granted_address [47:0]
    logic [1:0]        m_tuser;          // status [1:0]

    int unsigned       mismatches;
    int unsigned       expected_left;

    logic              modes_in_flight [$];
    logic [ADDR_W-1:0] live_offsets [$];
    logic [ADDR_W-1:0] base_now     = '0;
    int unsigned       quiet_cycles = 0;
    int unsigned       ready_hold   = 0;
    bit                steady       = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    buddy_allocator_tree #(
        .LEVELS     (LEVELS),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    buddy_tree_checker #(
        .LEVELS     (LEVELS),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) tree_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mismatches(mismatches),
        .awaited   (expected_left)
    );

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // track granted blocks as heap offsets, plus the idle watchdog
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) modes_in_flight.push_back(s_tuser);
        if (m_tvalid && m_tready && modes_in_flight.size() != 0) begin
            if (modes_in_flight.pop_front() == MODE_ALLOC && m_tuser == ST_OK)
                live_offsets.push_back(m_tdata - base_now);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (steady || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    task automatic push_txn(logic mode, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr_in);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {addr_in, req};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic alloc_txn(logic [REQ_W-1:0] req);
        logic [ADDR_W-1:0] junk;
        junk = ADDR_W'({$urandom, $urandom});
        push_txn(MODE_ALLOC, req, junk);
    endtask

    task automatic free_txn(logic [ADDR_W-1:0] addr_in);
        push_txn(MODE_FREE, $urandom, addr_in);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (modes_in_flight.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_base(logic [ADDR_W-1:0] v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        base_now = v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_txn();
        int                r, sel, alloc_share;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] noise;
        r = $urandom_range(0, 99);
        alloc_share = (live_offsets.size() < 8) ? 60 : 40;
        if (r < alloc_share) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)      alloc_txn($urandom_range(0, CHUNK_BYTES));
            else if (sel < 70) alloc_txn($urandom_range(0, 1024));
            else if (sel < 90) alloc_txn($urandom_range(0, HEAP_BYTES / 4));
            else               alloc_txn($urandom_range(0, HEAP_BYTES));
        end else if (r < alloc_share + 5) begin
            alloc_txn($urandom);
        end else if (r < 88 && live_offsets.size() != 0) begin
            sel = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[sel];
            live_offsets.delete(sel);
            free_txn(base_now + off);
        end else if (r < 93) begin
            off = ADDR_W'(longint'($urandom_range(0, HEAP_CHUNKS - 1)) * CHUNK_BYTES);
            free_txn(base_now + off);
        end else if (r < 97) begin
            off = ADDR_W'($urandom_range(0, HEAP_BYTES - 1));
            free_txn(base_now + off);
        end else begin
            noise = ADDR_W'({$urandom, $urandom});
            free_txn(noise);
        end
    endtask

    task automatic random_phase();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 4) == 0);
            random_txn();
        end
        steady = 0;
    endtask

    initial begin
        logic [ADDR_W-1:0] rand_base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        load_base('0);

        // rounding, oversize and the misc free errors
        alloc_txn(0);
        alloc_txn(1);
        alloc_txn(CHUNK_BYTES);
        alloc_txn(CHUNK_BYTES + 1);
        alloc_txn(HEAP_BYTES);
        alloc_txn(HEAP_BYTES + 1);
        alloc_txn(32'hFFFF_FFFF);
        free_txn(base_now + 1);
        free_txn(base_now + HEAP_BYTES);
        free_txn(base_now - CHUNK_BYTES);
        // inside a larger block, off its alignment
        free_txn(base_now + 5 * CHUNK_BYTES);
        free_txn(base_now + 4 * CHUNK_BYTES);
        free_txn(base_now + CHUNK_BYTES);
        free_txn(base_now + CHUNK_BYTES);
        free_txn(base_now);
        free_txn(base_now + 2 * CHUNK_BYTES);
        free_txn(base_now);
        alloc_txn(HEAP_BYTES);
        alloc_txn(0);
        free_txn(base_now);
        alloc_txn(HEAP_BYTES / 2);
        alloc_txn(HEAP_BYTES / 2);
        alloc_txn(HEAP_BYTES / 2);
        free_txn(base_now + HEAP_BYTES / 2);
        free_txn(base_now);
        drain();
        live_offsets.delete();

        random_phase();
        drain();

        load_base({ADDR_W{1'b1}});
        random_phase();
        drain();

        rand_base = ADDR_W'({$urandom, $urandom});
        load_base(rand_base);
        random_phase();
        drain();

        // heap wraps past the top of the address space
        load_base({ADDR_W{1'b1}} - HEAP_BYTES / 2 + 1);
        random_phase();
        drain();

        if (mismatches == 0 && expected_left == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
